/* hdl/kli_pkg.sv */
// Shared types and codes for the keyframe linear interpolator.
`default_nettype none
package kli_pkg;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam int DIV_STEPS = 17;

    typedef struct packed {
        logic signed [31:0] stamp;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_CHK,
        ST_Q_RD0,
        ST_Q_FIRST,
        ST_Q_RD,
        ST_Q_CHK,
        ST_DIV,
        ST_MUL,
        ST_ACC,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic load;
        logic load_add;
        logic set_full;
        logic set_empty;
        logic rd_en;
        logic rd_below;
        logic wr_new;
        logic wr_shift;
        logic latch_prev;
        logic inc_idx;
        logic res_rd;
        logic res_prev;
        logic div_start;
        logic div_step;
        logic mul;
        logic acc;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic one;
        logic idx_zero;
        logic rd_gt_t;
        logic bracket;
        logic same;
        logic last;
        logic div_done;
        logic coord_last;
        logic out_busy;
    } sts_t;

endpackage
`default_nettype wire

/* hdl/kli_datapath.sv */
// Datapath: sample memory, scan registers, serial divider and interpolation multiplier.
`default_nettype none
module kli_datapath #(
    parameter int MAX_SAMPLES = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire kli_pkg::cmd_t      cmd,
    output kli_pkg::sts_t           sts,
    input  wire logic signed [31:0] sample_stamp,
    input  wire logic signed [31:0] in_x,
    input  wire logic signed [31:0] in_y,
    input  wire logic signed [31:0] in_z,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      out_x,
    output logic signed [31:0]      out_y,
    output logic signed [31:0]      out_z,
    output logic [1:0]              status
);
    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW = $clog2(MAX_SAMPLES + 1);

    kli_pkg::entry_t mem [MAX_SAMPLES];
    kli_pkg::entry_t rdata_reg, prev_reg, new_reg;
    logic [AW-1:0]   idx_reg;
    logic [CW-1:0]   count_reg;
    logic [AW-1:0]   raddr;
    logic            we;
    kli_pkg::entry_t wdata;

    logic [32:0]     rem_reg;
    logic [31:0]     den_reg;
    logic [16:0]     frac_reg;
    logic [4:0]      dcnt_reg;
    logic [1:0]      coord_reg;
    logic signed [50:0] prod_reg;
    logic signed [31:0] res_x_reg, res_y_reg, res_z_reg;
    logic [1:0]      status_reg;
    logic            out_valid_reg;
    logic signed [31:0] out_x_reg, out_y_reg, out_z_reg;
    logic [1:0]      out_status_reg;

    logic signed [31:0] coord_a, coord_b;
    logic signed [32:0] diff;
    logic signed [50:0] prod_adj;
    logic signed [31:0] quot;
    logic [31:0]     lerp_sum;
    logic            div_ge;
    logic [32:0]     rem_sub;

    assign raddr = cmd.rd_below ? idx_reg - AW'(1) : idx_reg;
    assign we    = cmd.wr_new | cmd.wr_shift;
    assign wdata = cmd.wr_new ? new_reg : rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[idx_reg] <= wdata;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_comb
    begin
        unique case (coord_reg)
            2'd0:    begin coord_a = prev_reg.x; coord_b = rdata_reg.x; end
            2'd1:    begin coord_a = prev_reg.y; coord_b = rdata_reg.y; end
            default: begin coord_a = prev_reg.z; coord_b = rdata_reg.z; end
        endcase
        diff     = 33'(coord_b) - 33'(coord_a);
        prod_adj = prod_reg + ((prod_reg < 0) ? 51'sd65535 : 51'sd0);
        quot     = 32'(prod_adj >>> 16);
        lerp_sum = coord_a + quot;
        div_ge   = rem_reg >= {1'b0, den_reg};
        rem_sub  = div_ge ? rem_reg - {1'b0, den_reg} : rem_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            new_reg <= '{stamp: sample_stamp, x: in_x, y: in_y, z: in_z};
            res_x_reg <= '0;
            res_y_reg <= '0;
            res_z_reg <= '0;
        end
        if (cmd.latch_prev)
        begin
            prev_reg <= rdata_reg;
        end
        if (cmd.res_rd)
        begin
            res_x_reg <= rdata_reg.x;
            res_y_reg <= rdata_reg.y;
            res_z_reg <= rdata_reg.z;
        end
        if (cmd.res_prev)
        begin
            res_x_reg <= prev_reg.x;
            res_y_reg <= prev_reg.y;
            res_z_reg <= prev_reg.z;
        end
        if (cmd.div_start)
        begin
            rem_reg  <= {1'b0, new_reg.stamp - prev_reg.stamp};
            den_reg  <= rdata_reg.stamp - prev_reg.stamp;
            frac_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            frac_reg <= {frac_reg[15:0], div_ge};
            rem_reg  <= {rem_sub[31:0], 1'b0};
        end
        if (cmd.mul)
        begin
            prod_reg <= 51'(diff * $signed({1'b0, frac_reg}));
        end
        if (cmd.acc)
        begin
            unique case (coord_reg)
                2'd0:    res_x_reg <= lerp_sum;
                2'd1:    res_y_reg <= lerp_sum;
                default: res_z_reg <= lerp_sum;
            endcase
        end
        if (cmd.out_load)
        begin
            out_x_reg      <= res_x_reg;
            out_y_reg      <= res_y_reg;
            out_z_reg      <= res_z_reg;
            out_status_reg <= status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            dcnt_reg      <= '0;
            coord_reg     <= '0;
            status_reg    <= kli_pkg::STATUS_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg <= cmd.load_add ? count_reg[AW-1:0] : '0;
                status_reg <= cmd.set_full  ? kli_pkg::STATUS_FULL :
                              cmd.set_empty ? kli_pkg::STATUS_EMPTY : kli_pkg::STATUS_OK;
            end
            else if (cmd.wr_shift)
            begin
                idx_reg <= idx_reg - AW'(1);
            end
            else if (cmd.inc_idx)
            begin
                idx_reg <= idx_reg + AW'(1);
            end
            if (cmd.wr_new)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.div_start)
            begin
                dcnt_reg  <= 5'(kli_pkg::DIV_STEPS);
                coord_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                dcnt_reg <= dcnt_reg - 5'd1;
            end
            if (cmd.acc)
            begin
                coord_reg <= coord_reg + 2'd1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.full       = count_reg == CW'(MAX_SAMPLES);
    assign sts.empty      = count_reg == '0;
    assign sts.one        = count_reg == CW'(1);
    assign sts.idx_zero   = idx_reg == '0;
    assign sts.rd_gt_t    = rdata_reg.stamp > new_reg.stamp;
    assign sts.bracket    = (prev_reg.stamp <= new_reg.stamp) && (new_reg.stamp <= rdata_reg.stamp);
    assign sts.same       = prev_reg.stamp == rdata_reg.stamp;
    assign sts.last       = (CW'(idx_reg) + CW'(1)) == count_reg;
    assign sts.div_done   = dcnt_reg == '0;
    assign sts.coord_last = coord_reg == 2'd2;
    assign sts.out_busy   = out_valid_reg && out_stall;

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    assign status    = out_status_reg;
endmodule
`default_nettype wire

/* hdl/kli_ctrl.sv */
// Controller state machine sequencing insert, scan, divide and interpolate.
`default_nettype none
module kli_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          func,
    output logic               in_stall,
    input  wire kli_pkg::sts_t sts,
    output kli_pkg::cmd_t      cmd
);
    kli_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kli_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kli_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (func == kli_pkg::FUNC_ADD)
                    begin
                        state_next = sts.full ? kli_pkg::ST_RESULT : kli_pkg::ST_ADD_RD;
                    end
                    else
                    begin
                        state_next = sts.empty ? kli_pkg::ST_RESULT : kli_pkg::ST_Q_RD0;
                    end
                end
            end
            kli_pkg::ST_ADD_RD:
            begin
                state_next = sts.idx_zero ? kli_pkg::ST_RESULT : kli_pkg::ST_ADD_CHK;
            end
            kli_pkg::ST_ADD_CHK:
            begin
                state_next = sts.rd_gt_t ? kli_pkg::ST_ADD_RD : kli_pkg::ST_RESULT;
            end
            kli_pkg::ST_Q_RD0:   state_next = kli_pkg::ST_Q_FIRST;
            kli_pkg::ST_Q_FIRST:
            begin
                state_next = sts.one ? kli_pkg::ST_RESULT : kli_pkg::ST_Q_RD;
            end
            kli_pkg::ST_Q_RD:    state_next = kli_pkg::ST_Q_CHK;
            kli_pkg::ST_Q_CHK:
            begin
                priority if (sts.bracket)
                begin
                    state_next = sts.same ? kli_pkg::ST_RESULT : kli_pkg::ST_DIV;
                end
                else if (sts.last)
                begin
                    state_next = kli_pkg::ST_RESULT;
                end
                else
                begin
                    state_next = kli_pkg::ST_Q_RD;
                end
            end
            kli_pkg::ST_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = kli_pkg::ST_MUL;
                end
            end
            kli_pkg::ST_MUL:     state_next = kli_pkg::ST_ACC;
            kli_pkg::ST_ACC:
            begin
                state_next = sts.coord_last ? kli_pkg::ST_RESULT : kli_pkg::ST_MUL;
            end
            kli_pkg::ST_RESULT:
            begin
                if (!sts.out_busy)
                begin
                    state_next = kli_pkg::ST_IDLE;
                end
            end
            default:             state_next = kli_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            kli_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load      = 1'b1;
                    cmd.load_add  = func == kli_pkg::FUNC_ADD;
                    cmd.set_full  = (func == kli_pkg::FUNC_ADD) && sts.full;
                    cmd.set_empty = (func == kli_pkg::FUNC_QUERY) && sts.empty;
                end
            end
            kli_pkg::ST_ADD_RD:
            begin
                if (sts.idx_zero)
                begin
                    cmd.wr_new = 1'b1;
                end
                else
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.rd_below = 1'b1;
                end
            end
            kli_pkg::ST_ADD_CHK:
            begin
                cmd.wr_shift = sts.rd_gt_t;
                cmd.wr_new   = !sts.rd_gt_t;
            end
            kli_pkg::ST_Q_RD0:   cmd.rd_en = 1'b1;
            kli_pkg::ST_Q_FIRST:
            begin
                cmd.latch_prev = 1'b1;
                cmd.res_rd     = sts.one;
                cmd.inc_idx    = !sts.one;
            end
            kli_pkg::ST_Q_RD:    cmd.rd_en = 1'b1;
            kli_pkg::ST_Q_CHK:
            begin
                priority if (sts.bracket)
                begin
                    cmd.res_prev  = sts.same;
                    cmd.div_start = !sts.same;
                end
                else if (sts.last)
                begin
                    cmd.res_rd = 1'b1;
                end
                else
                begin
                    cmd.latch_prev = 1'b1;
                    cmd.inc_idx    = 1'b1;
                end
            end
            kli_pkg::ST_DIV:     cmd.div_step = !sts.div_done;
            kli_pkg::ST_MUL:     cmd.mul = 1'b1;
            kli_pkg::ST_ACC:     cmd.acc = 1'b1;
            kli_pkg::ST_RESULT:  cmd.out_load = !sts.out_busy;
            default:             cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

/* hdl/keyframe_linear_interpolator_unit.sv */
// Top level of the keyframe linear interpolator.
// Keeps up to MAX_SAMPLES time-stamped 3-D samples sorted by time and answers
// add and query requests. Both channels use valid/stall; a request moves on a
// rising edge with valid high and stall low.
// One request is worked at a time; in_stall is high from the accepting edge
// until the result is in the output register, and the next request can be
// taken in the cycle after that.
// Add: each stored sample above the insert point is read and moved up in
// turn (one memory read port), then the new sample is written.
// Query: fetch the first sample, scan the stored pairs, then a serial
// divide, a shared multiply for the three coordinates and a result step.
// A query on one entry, an empty query and an add on a full table skip
// the scan and the arithmetic.
// The result register lets a new request be taken while the last result
// waits; a stalled receiver holds the block in its result step only when a
// second result is ready.
// Reset empties the table; memory contents are not cleared.
`default_nettype none
module keyframe_linear_interpolator_unit #(
    parameter int MAX_SAMPLES = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               func,
    input  wire logic signed [31:0] sample_stamp,
    input  wire logic signed [31:0] in_x,
    input  wire logic signed [31:0] in_y,
    input  wire logic signed [31:0] in_z,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      out_x,
    output logic signed [31:0]      out_y,
    output logic signed [31:0]      out_z,
    output logic [1:0]              status
);
    kli_pkg::cmd_t cmd;
    kli_pkg::sts_t sts;

    kli_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    kli_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .sample_stamp (sample_stamp),
        .in_x         (in_x),
        .in_y         (in_y),
        .in_z         (in_z),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_z        (out_z),
        .status       (status)
    );
endmodule
`default_nettype wire

/* hdl/kli_checker.sv */
// Port-level assertions for the keyframe linear interpolator, with bind.
`default_nettype none
module kli_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] out_x,
    input wire logic [31:0] out_y,
    input wire logic [31:0] out_z,
    input wire logic [1:0]  status
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_x))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while previous in work");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == kli_pkg::STATUS_OK || status == kli_pkg::STATUS_FULL
                   || status == kli_pkg::STATUS_EMPTY)
        else $error("bad status code");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != kli_pkg::STATUS_OK |-> out_x == '0 && out_y == '0 && out_z == '0)
        else $error("error result with nonzero coordinates");
endmodule

bind keyframe_linear_interpolator_unit kli_checker u_kli_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .status    (status)
);
`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the keyframe linear interpolator unit.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = 64;
    localparam int N_RANDOM   = 1130;
    localparam int CYCLE_CAP  = 1000000;

    typedef struct {
        logic               fn;
        logic signed [31:0] t;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               known;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        logic signed [31:0] ez;
        logic [1:0]         est;
    } req_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [1:0]         st;
    } pos_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic func = kli_pkg::FUNC_ADD;
    logic signed [31:0] sample_stamp = '0;
    logic signed [31:0] in_x = '0;
    logic signed [31:0] in_y = '0;
    logic signed [31:0] in_z = '0;
    logic out_valid;
    logic out_stall = 1'b1;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [1:0] status;

    keyframe_linear_interpolator_unit #(.MAX_SAMPLES(DEPTH)) DUT (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic signed [31:0] key_t[DEPTH];
    logic signed [31:0] key_x[DEPTH];
    logic signed [31:0] key_y[DEPTH];
    logic signed [31:0] key_z[DEPTH];
    int key_count = 0;

    pos_t expected_pos[$];
    req_t directed[$];
    int errors = 0;
    int cycles = 0;
    logic hold_req = 1'b0;
    logic hold_off = 1'b0;
    logic sending_done = 1'b0;

    function automatic logic signed [31:0] lerp_coord(logic signed [31:0] a,
            logic signed [31:0] b, longint frac);
        longint prod;
        prod = (longint'(b) - longint'(a)) * frac;
        return 32'(longint'(a) + prod / 65536);
    endfunction

    function automatic pos_t apply_request(logic fn, logic signed [31:0] t,
            logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
        pos_t r;
        int pos;
        int sel;
        longint num;
        longint den;
        longint frac;
        r = '{x: '0, y: '0, z: '0, st: kli_pkg::STATUS_OK};
        if (fn == kli_pkg::FUNC_ADD) begin
            if (key_count >= DEPTH)
                r.st = kli_pkg::STATUS_FULL;
            else begin
                pos = 0;
                while (pos < key_count && key_t[pos] <= t)
                    pos++;
                for (int k = key_count; k > pos; k--) begin
                    key_t[k] = key_t[k-1];
                    key_x[k] = key_x[k-1];
                    key_y[k] = key_y[k-1];
                    key_z[k] = key_z[k-1];
                end
                key_t[pos] = t;
                key_x[pos] = x;
                key_y[pos] = y;
                key_z[pos] = z;
                key_count++;
            end
        end else if (key_count == 0)
            r.st = kli_pkg::STATUS_EMPTY;
        else if (key_count == 1)
            r = '{x: key_x[0], y: key_y[0], z: key_z[0], st: kli_pkg::STATUS_OK};
        else begin
            sel = -1;
            for (int i = 0; i + 1 < key_count; i++)
                if (sel < 0 && t >= key_t[i] && t <= key_t[i+1])
                    sel = i;
            if (sel < 0)
                r = '{x: key_x[key_count-1], y: key_y[key_count-1],
                      z: key_z[key_count-1], st: kli_pkg::STATUS_OK};
            else if (key_t[sel] == key_t[sel+1])
                r = '{x: key_x[sel], y: key_y[sel], z: key_z[sel], st: kli_pkg::STATUS_OK};
            else begin
                num = longint'(t) - longint'(key_t[sel]);
                den = longint'(key_t[sel+1]) - longint'(key_t[sel]);
                frac = (num * 65536) / den;
                r.x = lerp_coord(key_x[sel], key_x[sel+1], frac);
                r.y = lerp_coord(key_y[sel], key_y[sel+1], frac);
                r.z = lerp_coord(key_z[sel], key_z[sel+1], frac);
            end
        end
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    endtask

    task automatic row(logic fn, logic signed [31:0] t, logic signed [31:0] x,
            logic signed [31:0] y, logic signed [31:0] z, logic known = 1'b0,
            logic [1:0] est = kli_pkg::STATUS_OK);
        directed.insert(directed.size(),
                        '{fn, t, x, y, z, known, 32'sd0, 32'sd0, 32'sd0, est});
    endtask

    task automatic send(logic fn, logic signed [31:0] t, logic signed [31:0] x,
            logic signed [31:0] y, logic signed [31:0] z);
        pos_t p;
        int gap;
        gap = $urandom_range(0, 8);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= fn;
        sample_stamp <= t;
        in_x <= x;
        in_y <= y;
        in_z <= z;
        do @(posedge clk); while (in_stall);
        p = apply_request(fn, t, x, y, z);
        expected_pos.insert(expected_pos.size(), p);
    endtask

    function automatic logic signed [31:0] rand_stamp(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 40)) - 20;
            default: return $signed($urandom_range(0, 4000)) - 2000;
        endcase
    endfunction

    initial
    begin
        int mode;
        int i;
        row(kli_pkg::FUNC_QUERY, 32'sd0, '0, '0, '0, 1'b1, kli_pkg::STATUS_EMPTY);
        row(kli_pkg::FUNC_QUERY, 32'h8000_0000, '0, '0, '0, 1'b1, kli_pkg::STATUS_EMPTY);
        row(kli_pkg::FUNC_ADD, 32'sd100, 32'h7fff_ffff, 32'h8000_0000, 32'sd5, 1'b1,
            kli_pkg::STATUS_OK);
        row(kli_pkg::FUNC_QUERY, 32'h7fff_ffff, '0, '0, '0);
        row(kli_pkg::FUNC_ADD, 32'sd200, 32'h8000_0000, 32'h7fff_ffff, -32'sd5, 1'b1,
            kli_pkg::STATUS_OK);
        row(kli_pkg::FUNC_QUERY, 32'sd150, '0, '0, '0);
        row(kli_pkg::FUNC_QUERY, 32'sd200, '0, '0, '0);
        row(kli_pkg::FUNC_QUERY, 32'sd101, '0, '0, '0);
        row(kli_pkg::FUNC_QUERY, 32'sd50, '0, '0, '0);
        row(kli_pkg::FUNC_QUERY, 32'sd300, '0, '0, '0);
        row(kli_pkg::FUNC_ADD, 32'sd100, 32'sd7, 32'sd8, 32'sd9, 1'b1, kli_pkg::STATUS_OK);
        row(kli_pkg::FUNC_QUERY, 32'sd100, '0, '0, '0);
        row(kli_pkg::FUNC_ADD, 32'h8000_0000, 32'sd1, 32'sd2, 32'sd3, 1'b1,
            kli_pkg::STATUS_OK);
        row(kli_pkg::FUNC_ADD, 32'h7fff_ffff, -32'sd1, -32'sd2, -32'sd3, 1'b1,
            kli_pkg::STATUS_OK);
        row(kli_pkg::FUNC_QUERY, 32'sd0, '0, '0, '0);
        row(kli_pkg::FUNC_QUERY, 32'h7fff_fffe, '0, '0, '0);
        row(kli_pkg::FUNC_QUERY, 32'h8000_0000, '0, '0, '0);
        row(kli_pkg::FUNC_QUERY, 32'hffff_ffff, '0, '0, '0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[j]) begin
            send(directed[j].fn, directed[j].t, directed[j].x, directed[j].y, directed[j].z);
            if (directed[j].known && expected_pos[$].st != directed[j].est)
                report("directed status", expected_pos[$].st, directed[j].est);
            if (directed[j].known && expected_pos[$].x != directed[j].ex)
                report("directed x", expected_pos[$].x, directed[j].ex);
            if (directed[j].known && expected_pos[$].y != directed[j].ey)
                report("directed y", expected_pos[$].y, directed[j].ey);
            if (directed[j].known && expected_pos[$].z != directed[j].ez)
                report("directed z", expected_pos[$].z, directed[j].ez);
        end

        i = 0;
        while (i < N_RANDOM) begin
            mode = $urandom_range(0, 2);
            if (key_count < DEPTH && $urandom_range(0, 99) < 45)
                send(kli_pkg::FUNC_ADD, rand_stamp(mode), $urandom, $urandom, $urandom);
            else
                send(kli_pkg::FUNC_QUERY, rand_stamp(mode), $urandom, $urandom, $urandom);
            i++;
        end

        // fill to capacity, then overflow with the receiver held off
        while (key_count < DEPTH)
            send(kli_pkg::FUNC_ADD, rand_stamp(2), $urandom, $urandom, $urandom);
        hold_req <= 1'b1;
        for (i = 0; i < 4; i++) begin
            send(kli_pkg::FUNC_ADD, rand_stamp(0), $urandom, $urandom, $urandom);
            if (expected_pos[$].st != kli_pkg::STATUS_FULL)
                report("full status", expected_pos[$].st, kli_pkg::STATUS_FULL);
        end
        in_valid <= 1'b0;
        sending_done <= 1'b1;
    end

    initial
    begin
        wait (hold_req);
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        pos_t want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_pos.size() == 0)
                    report("unexpected result", status, -1);
                else begin
                    want = expected_pos.pop_front();
                    if (out_x !== want.x) report("out_x", out_x, want.x);
                    if (out_y !== want.y) report("out_y", out_y, want.y);
                    if (out_z !== want.z) report("out_z", out_z, want.z);
                    if (status !== want.st) report("status", status, want.st);
                end
            end
        end
    end

    int stall_left = 0;
    always @(posedge clk)
    begin
        int gap;
        if (hold_off)
            out_stall <= 1'b1;
        else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end else if (out_valid && !out_stall) begin
            gap = $urandom_range(0, 8);
            stall_left <= (gap > 0) ? gap - 1 : 0;
            out_stall <= (gap > 0);
        end else
            out_stall <= 1'b0;
    end

    initial
    begin
        wait (sending_done);
        while (expected_pos.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("** keyframe_linear_interpolator_unit: PASSED **");
        else
            $display("** keyframe_linear_interpolator_unit: FAILED **");
        $finish;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("** keyframe_linear_interpolator_unit: FAILED **");
            $finish;
        end
    end
endmodule
`default_nettype wire

/* keyframe_linear_interpolator_unit.f */
hdl/kli_pkg.sv
hdl/kli_datapath.sv
hdl/kli_ctrl.sv
hdl/keyframe_linear_interpolator_unit.sv
hdl/kli_checker.sv
verif/tb.sv
